>>> sv/pmsp_pkg.sv
// Shared types and constants for the PCA mean-subtract projection unit.
// Used by every module of the block except pmsp_ram; depends on nothing.
`default_nettype none

package pmsp_pkg;

  localparam int FEATURES_DEF   = 256;
  localparam int COMPONENTS_DEF = 100;

  localparam int VALUE_W = 16;   // Q7.8 feature/mean, Q1.14 coefficient
  localparam int DIFF_W  = 17;   // Q8.8 difference
  localparam int PROD_W  = 33;   // exact Q.22 product
  localparam int ACC_W   = 41;   // Q.22 accumulator, wraps
  localparam int READ_SHIFT = 14;
  localparam int PROJ_W  = 32;
  localparam int COMP_W  = 7;
  localparam int FIDX_W  = 8;

  typedef enum logic [1:0] {
    MODE_MEAN    = 2'd0,
    MODE_COEF    = 2'd1,
    MODE_FEATURE = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ
  } state_t;

  typedef struct packed {
    mode_t                     mode;
    logic [COMP_W-1:0]         component;
    logic [FIDX_W-1:0]         feature_index;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [COMP_W-1:0]        out_component;
    logic signed [PROJ_W-1:0] projection;
  } result_t;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic take;       // item beat accepted this cycle
    logic load_diff;  // mean read data valid: form x - mean
    logic mac_b;      // coefficient and accumulator read data valid
    logic clr;        // treat old accumulator as zero in this sweep
    logic load_out;   // accumulator read data valid for a component read
    logic out_zero;   // component read returns zero
  } ctrl_t;

endpackage

`default_nettype wire

>>> sv/pmsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module pmsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/pmsp_ctrl.sv
// Sequencer: decodes item beats, drives table addresses, and walks the
// component sweep through the shared MAC pipeline. Uses pmsp_pkg.
`default_nettype none

module pmsp_ctrl #(
  parameter int FEATURES   = pmsp_pkg::FEATURES_DEF,
  parameter int COMPONENTS = pmsp_pkg::COMPONENTS_DEF,
  localparam int FA = $clog2(FEATURES),
  localparam int CA = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1,
  localparam int KA = $clog2(FEATURES * COMPONENTS)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire pmsp_pkg::item_t item,
  output logic                 busy,
  output logic                 strobe,
  output pmsp_pkg::ctrl_t      ctl,
  output logic                 mean_we,
  output logic [FA-1:0]        mean_waddr,
  output logic [FA-1:0]        mean_raddr,
  output logic                 coef_we,
  output logic [KA-1:0]        coef_waddr,
  output logic [KA-1:0]        coef_raddr,
  output logic [CA-1:0]        acc_raddr,
  output logic                 acc_we,
  output logic [CA-1:0]        acc_waddr
);
  import pmsp_pkg::*;

  state_t        state, state_next;
  logic [CA-1:0] cnt;
  logic [KA-1:0] caddr;
  logic          v1, v2;
  logic [CA-1:0] a1, a2;
  logic          clr_r, zero_r, fresh;

  logic accept, fidx_ok, comp_ok, issue, last;

  assign accept  = start && !busy;
  assign fidx_ok = 32'(item.feature_index) < FEATURES;
  assign comp_ok = 32'(item.component) < COMPONENTS;
  assign last    = cnt == CA'(COMPONENTS - 1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.mode) inside
            MODE_FEATURE:        state_next = fidx_ok ? ST_MEAN : ST_IDLE;
            MODE_READ:           state_next = ST_READ;
            MODE_MEAN, MODE_COEF: state_next = ST_IDLE;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_MEAN, ST_SWEEP: state_next = last ? ST_DRAIN : ST_SWEEP;
      ST_DRAIN:          state_next = v1 ? ST_DRAIN : ST_IDLE;
      ST_READ:           state_next = ST_IDLE;
      default:           state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy          = state != ST_IDLE;
    issue         = (state == ST_MEAN) || (state == ST_SWEEP);
    ctl.take      = accept;
    ctl.load_diff = state == ST_MEAN;
    ctl.mac_b     = v1;
    ctl.clr       = clr_r;
    ctl.load_out  = state == ST_READ;
    ctl.out_zero  = zero_r;
    mean_we       = accept && (item.mode == MODE_MEAN) && fidx_ok;
    mean_waddr    = FA'(item.feature_index);
    mean_raddr    = FA'(item.feature_index);
    coef_we       = accept && (item.mode == MODE_COEF) && fidx_ok && comp_ok;
    coef_waddr    = KA'(32'(item.feature_index) * COMPONENTS + 32'(item.component));
    coef_raddr    = caddr;
    acc_raddr     = (state == ST_IDLE) ? CA'(item.component) : cnt;
    acc_we        = v2;
    acc_waddr     = a2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      v1     <= 1'b0;
      v2     <= 1'b0;
      fresh  <= 1'b1;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      v1     <= issue;
      v2     <= v1;
      strobe <= state == ST_READ;
      // Every entry has been written once the first sweep retires.
      if (state == ST_DRAIN && !v1) begin
        fresh <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a1 <= cnt;
    a2 <= a1;
    if (accept) begin
      cnt    <= '0;
      caddr  <= KA'(32'(item.feature_index) * COMPONENTS);
      clr_r  <= (item.feature_index == '0) || fresh;
      zero_r <= !comp_ok || fresh;
    end else if (issue) begin
      cnt   <= cnt + CA'(1);
      caddr <= caddr + KA'(1);
    end
  end

endmodule

`default_nettype wire

>>> sv/pmsp_mac.sv
// Shared datapath: mean subtract, one signed multiply-accumulate per cycle,
// and the read-out shift into the result register. Uses pmsp_pkg.
`default_nettype none

module pmsp_mac (
  input  wire logic                          clk,
  input  wire pmsp_pkg::ctrl_t               ctl,
  input  wire pmsp_pkg::item_t               item,
  input  wire logic [pmsp_pkg::VALUE_W-1:0]  mean_q,
  input  wire logic [pmsp_pkg::VALUE_W-1:0]  coef_q,
  input  wire logic [pmsp_pkg::ACC_W-1:0]    acc_q,
  output logic      [pmsp_pkg::ACC_W-1:0]    acc_wdata,
  output pmsp_pkg::result_t                  result
);
  import pmsp_pkg::*;

  logic signed [VALUE_W-1:0] value_r;
  logic [COMP_W-1:0]         comp_r;
  logic signed [DIFF_W-1:0]  diff, diff_r;
  logic signed [PROD_W-1:0]  prod, prod_r;
  logic signed [ACC_W-1:0]   accq_r, sum;
  logic signed [PROJ_W-1:0]  proj;

  assign diff = DIFF_W'(value_r) - DIFF_W'(signed'(mean_q));
  assign prod = PROD_W'(diff_r) * PROD_W'(signed'(coef_q));
  assign sum  = accq_r + ACC_W'(prod_r);
  assign acc_wdata = sum;

  // Floor shift; the 27-bit quotient always fits the 32-bit result.
  assign proj = PROJ_W'(signed'(acc_q[ACC_W-1:READ_SHIFT]));

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      value_r <= item.value;
      comp_r  <= item.component;
    end
    if (ctl.load_diff) begin
      diff_r <= diff;
    end
    if (ctl.mac_b) begin
      prod_r <= prod;
      accq_r <= ctl.clr ? '0 : signed'(acc_q);
    end
    if (ctl.load_out) begin
      result.out_component <= comp_r;
      result.projection    <= ctl.out_zero ? '0 : proj;
    end
  end

endmodule

`default_nettype wire

>>> sv/pca_mean_subtract_projection_unit.sv
// Mean and coefficient loads: taken without raising busy.
// Feature element: busy through the sweep and the drain (one MAC per component
// through the shared multiplier and the accumulator RAM port), next beat once idle.
// Component read: busy 1 cycle, result and strobe registered at the end of ST_READ.
// Reset clears control and makes all accumulators read as zero until the first
// feature sweep; mean and coefficient tables are undefined until written.
`default_nettype none

module pca_mean_subtract_projection_unit #(
  parameter int FEATURES   = pmsp_pkg::FEATURES_DEF,
  parameter int COMPONENTS = pmsp_pkg::COMPONENTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire pmsp_pkg::item_t   item,
  output logic                   busy,
  output logic                   strobe,
  output pmsp_pkg::result_t      result
);
  import pmsp_pkg::*;

  localparam int FA = $clog2(FEATURES);
  localparam int CA = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int KA = $clog2(FEATURES * COMPONENTS);

  ctrl_t               ctl;
  logic                mean_we, coef_we, acc_we;
  logic [FA-1:0]       mean_waddr, mean_raddr;
  logic [KA-1:0]       coef_waddr, coef_raddr;
  logic [CA-1:0]       acc_raddr, acc_waddr;
  logic [VALUE_W-1:0]  mean_q, coef_q;
  logic [ACC_W-1:0]    acc_q, acc_wdata;

  pmsp_ctrl #(
    .FEATURES  (FEATURES),
    .COMPONENTS(COMPONENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .strobe    (strobe),
    .ctl       (ctl),
    .mean_we   (mean_we),
    .mean_waddr(mean_waddr),
    .mean_raddr(mean_raddr),
    .coef_we   (coef_we),
    .coef_waddr(coef_waddr),
    .coef_raddr(coef_raddr),
    .acc_raddr (acc_raddr),
    .acc_we    (acc_we),
    .acc_waddr (acc_waddr)
  );

  pmsp_ram #(.WIDTH(VALUE_W), .DEPTH(FEATURES)) u_mean_ram (
    .clk  (clk),
    .we   (mean_we),
    .waddr(mean_waddr),
    .wdata(item.value),
    .raddr(mean_raddr),
    .rdata(mean_q)
  );

  pmsp_ram #(.WIDTH(VALUE_W), .DEPTH(FEATURES * COMPONENTS)) u_coef_ram (
    .clk  (clk),
    .we   (coef_we),
    .waddr(coef_waddr),
    .wdata(item.value),
    .raddr(coef_raddr),
    .rdata(coef_q)
  );

  pmsp_ram #(.WIDTH(ACC_W), .DEPTH(COMPONENTS)) u_acc_ram (
    .clk  (clk),
    .we   (acc_we),
    .waddr(acc_waddr),
    .wdata(acc_wdata),
    .raddr(acc_raddr),
    .rdata(acc_q)
  );

  pmsp_mac u_mac (
    .clk      (clk),
    .ctl      (ctl),
    .item     (item),
    .mean_q   (mean_q),
    .coef_q   (coef_q),
    .acc_q    (acc_q),
    .acc_wdata(acc_wdata),
    .result   (result)
  );

`ifndef SYNTHESIS
  // A read beat is answered by a strobe once ST_READ has passed.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.mode == MODE_READ) |-> ##2 strobe)
    else $error("read beat not answered in two cycles");

  // A result only appears as the read finishes and releases the block.
  a_strobe_after_read: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(busy) && !busy))
    else $error("result strobe outside a read");

  // Accumulator writes happen only inside a sweep.
  a_acc_write_busy: assert property (@(posedge clk) disable iff (rst)
    acc_we |-> busy)
    else $error("accumulator written while idle");
`endif

endmodule

`default_nettype wire
